@@ rtl/maw_pkg.sv @@
// ----------------------------------------------------------------------------
// maw_pkg: shared types and constants for the moving average core
// Item layouts of both channels, operation codes and the fixed field widths.
// ----------------------------------------------------------------------------
package maw_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 9;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic                       operation;
    logic signed [SAMPLE_W-1:0] sample;
  } maw_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average;
    logic                       window_full;
  } maw_out_t;

endpackage

@@ rtl/maw_ram.sv @@
// ----------------------------------------------------------------------------
// maw_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module maw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/maw_div.sv @@
// ----------------------------------------------------------------------------
// maw_div: bit-serial signed divider
// Restoring division of a signed sum by an unsigned nonzero count, one
// quotient bit per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module maw_div #(
  parameter int DIVIDEND_W = 24,
  parameter int DIVISOR_W  = 9
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]         divisor,
  output logic                         done,
  output logic signed [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  neg_r, neg_nxt;
  logic [DIVIDEND_W-1:0] mag_r, mag_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  den_r, den_nxt;

  logic [DIVISOR_W:0]    rem_shift;
  logic [DIVISOR_W:0]    rem_diff;
  logic                  fits;

  assign rem_shift = {rem_r, mag_r[DIVIDEND_W-1]};
  assign fits      = rem_shift >= {1'b0, den_r};
  assign rem_diff  = rem_shift - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIVIDEND_W - 1);
      neg_nxt  = dividend[DIVIDEND_W-1];
      // the most negative sum maps onto its own pattern, read as unsigned
      mag_nxt  = dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);
      rem_nxt  = '0;
      den_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
      mag_nxt = {mag_r[DIVIDEND_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(mag_r) : $signed(mag_r);

endmodule

@@ rtl/moving_average_warmup_core.sv @@
// ----------------------------------------------------------------------------
// moving_average_warmup_core: boxcar moving average with warm-up
// Keeps the recent samples in a ring RAM and a running sum; each push emits
// the sum divided by the number of samples held, truncated toward zero.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   maw_in_t  (operation, sample)
//   out_     output     out_valid/out_stall maw_out_t (average, window_full)
//   cfg_     input      cfg_we              window_length (9 bits)
//
// A push in warm-up passes the start and divide states; once the window is
// full it first passes the update state, which uses the ring RAM read of the
// oldest sample. The bit-serial divider gives one quotient bit per cycle over
// the sum width. A clear is done in the idle state. in_stall is high while an
// item is in work and while a finished result waits for the output register.
// Reset sets window length min(8, MAX_WINDOW), empties history; no RAM sweep.
// ----------------------------------------------------------------------------
module moving_average_warmup_core #(
  parameter int MAX_WINDOW = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  maw_pkg::maw_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output maw_pkg::maw_out_t           out_data,
  input  logic                        cfg_we,
  input  logic [maw_pkg::CFG_W-1:0]   cfg_wdata
);

  import maw_pkg::*;

  localparam int ADDR_W  = $clog2(MAX_WINDOW);
  localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W   = SAMPLE_W + ADDR_W;
  localparam int CMP_W   = (WIN_W > CFG_W) ? WIN_W : CFG_W;
  localparam int WIN_RST = (MAX_WINDOW < 8) ? MAX_WINDOW : 8;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UPDATE = 3'd1;
  localparam logic [2:0] S_START  = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_HOLD   = 3'd4;

  logic [2:0]                 state_r, state_nxt;
  logic [WIN_W-1:0]           win_r, win_nxt;
  logic [WIN_W-1:0]           fill_r, fill_nxt;
  logic [ADDR_W-1:0]          ptr_r, ptr_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic signed [SAMPLE_W-1:0] x_r, x_nxt;
  logic [WIN_W-1:0]           den_r, den_nxt;
  logic                       full_r, full_nxt;
  logic                       out_valid_r, out_valid_nxt;
  maw_out_t                   out_data_r, out_data_nxt;

  logic                       in_accept;
  logic                       out_free;
  logic                       load_out;
  logic [WIN_W-1:0]           fill_inc;
  logic [WIN_W-1:0]           ptr_inc;
  logic [CMP_W-1:0]           cfg_ext;

  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_waddr;
  logic [SAMPLE_W-1:0]        ram_wdata;
  logic [SAMPLE_W-1:0]        ram_rdata;

  logic                       div_start;
  logic                       div_done;
  logic signed [SUM_W-1:0]    div_quot;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign fill_inc  = fill_r + WIN_W'(1);
  assign ptr_inc   = WIN_W'(ptr_r) + WIN_W'(1);
  assign cfg_ext   = CMP_W'(cfg_wdata);

  maw_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  maw_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (WIN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    state_nxt = state_r;
    win_nxt   = win_r;
    fill_nxt  = fill_r;
    ptr_nxt   = ptr_r;
    sum_nxt   = sum_r;
    x_nxt     = x_r;
    den_nxt   = den_r;
    full_nxt  = full_r;
    ram_we    = 1'b0;
    ram_waddr = fill_r[ADDR_W-1:0];
    ram_wdata = in_data.sample;
    div_start = 1'b0;
    load_out  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (in_data.operation == OP_CLEAR) begin
            fill_nxt = '0;
            ptr_nxt  = '0;
            sum_nxt  = '0;
          end else if (fill_r < win_r) begin
            // warm-up: append at the fill position
            ram_we    = 1'b1;
            sum_nxt   = sum_r + SUM_W'(in_data.sample);
            fill_nxt  = fill_inc;
            den_nxt   = fill_inc;
            full_nxt  = (fill_inc == win_r);
            state_nxt = S_START;
          end else begin
            // full window: the oldest sample is being read from the ring
            x_nxt     = in_data.sample;
            state_nxt = S_UPDATE;
          end
        end
      end
      S_UPDATE: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        ram_wdata = x_r;
        sum_nxt   = sum_r + SUM_W'(x_r) - SUM_W'($signed(ram_rdata));
        ptr_nxt   = (ptr_inc >= win_r) ? '0 : ptr_inc[ADDR_W-1:0];
        den_nxt   = win_r;
        full_nxt  = 1'b1;
        state_nxt = S_START;
      end
      S_START: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          if (out_free) begin
            load_out  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        // divider keeps its quotient until the output register frees up
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      if (cfg_ext == '0) begin
        win_nxt = WIN_W'(1);
      end else if (cfg_ext > CMP_W'(MAX_WINDOW)) begin
        win_nxt = WIN_W'(MAX_WINDOW);
      end else begin
        win_nxt = WIN_W'(cfg_ext);
      end
      fill_nxt = '0;
      ptr_nxt  = '0;
      sum_nxt  = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (load_out) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.average     = div_quot[SAMPLE_W-1:0];
      out_data_nxt.window_full = full_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      win_r       <= WIN_W'(WIN_RST);
      fill_r      <= '0;
      ptr_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      win_r       <= win_nxt;
      fill_r      <= fill_nxt;
      ptr_r       <= ptr_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    den_r      <= den_nxt;
    full_r     <= full_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_push_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_data.operation == OP_PUSH) |=> in_stall)
    else $error("push item accepted but block did not go busy");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= win_r)
    else $error("fill count exceeds window length");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    WIN_W'(ptr_r) < win_r)
    else $error("oldest pointer outside window");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide state");

endmodule

@@ tb/tb_moving_average_warmup_core.sv @@
// ----------------------------------------------------------------------------
// tb_moving_average_warmup_core: self-checking bench for the moving average
// A short table of hand-picked pushes and clears at the reset window length
// comes first. After it come phases of random items at window lengths from
// one up to the saturated maximum. Every accepted push goes through a local
// ring and running-sum predictor, and each result is compared in order. Both
// channels idle at random. The receiver holds off long enough to back up the
// core, and the sender now and then waits for the core to drain.
// ----------------------------------------------------------------------------
module tb_moving_average_warmup_core;
  import maw_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RING_DEPTH     = 256;
  localparam int SETTLE_CYCLES  = 40;
  localparam int LONG_HOLD      = 300;
  localparam int TIMEOUT_CYCLES = 600000;
  localparam int DIR_ROWS       = 25;
  localparam int NUM_PHASES     = 9;
  localparam int RANDOM_WINDOW  = -1;

  typedef struct {
    logic                       op;
    logic signed [SAMPLE_W-1:0] smp;
    bit                         typed;
    logic signed [SAMPLE_W-1:0] avg;
    logic                       full;
  } dir_row_t;

  typedef struct {
    int          cfg;
    int unsigned items;
    int unsigned clear_odds;
  } phase_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  maw_in_t           in_data;
  logic              out_valid;
  logic              out_stall;
  maw_out_t          out_data;
  logic              cfg_we;
  logic [CFG_W-1:0]  cfg_wdata;

  // predictor state
  logic signed [SAMPLE_W-1:0] ring_model [RING_DEPTH];
  int unsigned                oldest_idx;
  int unsigned                fill_cnt;
  int unsigned                win_len;
  longint                     window_sum;

  maw_out_t    pending_averages [$];
  int unsigned fail_count;
  bit          long_hold_req;

  // window length 8 after reset
  dir_row_t directed_rows [DIR_ROWS] = '{
    '{OP_PUSH,   32767, 1,  32767, 0},
    '{OP_PUSH,  -32768, 1,      0, 0},  // -1 / 2 truncates toward zero
    '{OP_PUSH,  -32768, 0,      0, 0},
    '{OP_PUSH,       0, 0,      0, 0},
    '{OP_PUSH,       1, 0,      0, 0},
    '{OP_PUSH,      -1, 0,      0, 0},
    '{OP_PUSH,   12345, 0,      0, 0},
    '{OP_PUSH,  -32768, 0,      0, 0},  // completes warm-up
    '{OP_PUSH,   32767, 0,      0, 0},  // swaps out the oldest sample
    '{OP_CLEAR,  32767, 0,      0, 0},
    '{OP_PUSH,  -32768, 1, -32768, 0},
    '{OP_PUSH,  -32768, 1, -32768, 0},
    '{OP_CLEAR, -32768, 0,      0, 0},
    '{OP_PUSH,      -1, 1,     -1, 0},
    '{OP_PUSH,       0, 1,      0, 0},
    '{OP_PUSH,      -2, 1,     -1, 0},
    '{OP_CLEAR,      0, 0,      0, 0},
    '{OP_PUSH,  -32768, 1, -32768, 0},
    '{OP_PUSH,  -32768, 1, -32768, 0},
    '{OP_PUSH,  -32768, 1, -32768, 0},
    '{OP_PUSH,  -32768, 1, -32768, 0},
    '{OP_PUSH,  -32768, 1, -32768, 0},
    '{OP_PUSH,  -32768, 1, -32768, 0},
    '{OP_PUSH,  -32768, 1, -32768, 0},
    '{OP_PUSH,  -32768, 1, -32768, 1}
  };

  phase_t phases [NUM_PHASES] = '{
    '{0,             40,  8},   // zero acts as one
    '{1,             30,  8},
    '{256,           270, 300},
    '{511,           270, 300}, // saturates to the ring depth
    '{2,             40,  10},
    '{3,             40,  10},
    '{RANDOM_WINDOW, 80,  30},
    '{RANDOM_WINDOW, 80,  30},
    '{RANDOM_WINDOW, 80,  30}
  };

  moving_average_warmup_core #(
    .MAX_WINDOW(RING_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Mismatches found");
    $finish;
  end

  function automatic void clear_history();
    oldest_idx = 0;
    fill_cnt   = 0;
    window_sum = 0;
  endfunction

  function automatic void set_window(input logic [CFG_W-1:0] v);
    if (v == 0) begin
      win_len = 1;
    end else if (v > RING_DEPTH) begin
      win_len = RING_DEPTH;
    end else begin
      win_len = 32'(v);
    end
    clear_history();
  endfunction

  // Return 1 and the expected result for a push, 0 for a clear.
  function automatic bit average_step(input maw_in_t it, output maw_out_t res);
    longint x;
    longint q;
    res = '0;
    if (it.operation == OP_CLEAR) begin
      clear_history();
      return 1'b0;
    end
    x = longint'($signed(it.sample));
    if (fill_cnt < win_len) begin
      ring_model[fill_cnt] = it.sample;
      window_sum += x;
      fill_cnt++;
      q = window_sum / longint'(fill_cnt);
      res.window_full = (fill_cnt == win_len);
    end else begin
      window_sum += x - longint'(ring_model[oldest_idx]);
      ring_model[oldest_idx] = it.sample;
      oldest_idx = (oldest_idx + 1 >= win_len) ? 0 : oldest_idx + 1;
      q = window_sum / longint'(win_len);
      res.window_full = 1'b1;
    end
    res.average = q[SAMPLE_W-1:0];
    return 1'b1;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return SAMPLE_W'($urandom_range(0, 6) - 3);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Offer one item after a gap and hold it until the core takes it.
  task automatic send_item(input maw_in_t it, input int unsigned gap,
                           input bit use_typed, input maw_out_t typed_res);
    maw_out_t res;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (average_step(it, res)) pending_averages.push_back(use_typed ? typed_res : res);
  endtask

  // Stop offering, wait for every result, then let a trailing clear finish.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    set_window(v);
  endtask

  initial begin : stimulus
    maw_in_t          it;
    maw_out_t         typed_res;
    logic [CFG_W-1:0] wv;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    long_hold_req = 1'b0;
    fail_count    = 0;
    rst_n         = 1'b0;
    win_len       = 8;
    clear_history();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      it.operation          = directed_rows[i].op;
      it.sample             = directed_rows[i].smp;
      typed_res.average     = directed_rows[i].avg;
      typed_res.window_full = directed_rows[i].full;
      send_item(it, pick_gap(), directed_rows[i].typed, typed_res);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      if (phases[p].cfg == RANDOM_WINDOW) begin
        wv = CFG_W'($urandom_range(4, 40));
      end else begin
        wv = CFG_W'(phases[p].cfg);
      end
      write_window(wv);
      for (int k = 0; k < phases[p].items; k++) begin
        if (k == phases[p].items / 2) begin
          // back up the core from the result side, or let it run dry
          if (p % 2 == 0) begin
            long_hold_req = 1'b1;
          end else begin
            drain_results();
          end
        end
        it.operation = ($urandom_range(1, phases[p].clear_odds) == 1) ? OP_CLEAR : OP_PUSH;
        it.sample    = pick_sample();
        send_item(it, pick_gap(), 1'b0, '0);
      end
    end

    drain_results();
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : result_stall
    int unsigned hold_len;
    bit          hold_val;
    bit          long_taken;
    out_stall = 1'b0;
    forever begin
      long_taken = long_hold_req;
      if (long_taken) begin
        hold_val = 1'b1;
        hold_len = LONG_HOLD;
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5: begin
            hold_val = 1'b1;
            hold_len = $urandom_range(1, 3);
          end
          16: begin
            hold_val = 1'b1;
            hold_len = $urandom_range(20, 60);
          end
          17, 18, 19: begin
            hold_val = 1'b0;
            hold_len = $urandom_range(50, 200);
          end
          default: begin
            hold_val = 1'b0;
            hold_len = $urandom_range(1, 8);
          end
        endcase
      end
      @(negedge clk);
      out_stall <= hold_val;
      repeat (hold_len - 1) @(negedge clk);
      if (long_taken) long_hold_req = 1'b0;
    end
  end

  always @(posedge clk) begin
    maw_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_averages.size() == 0) begin
        $display("%0t: unexpected result, average %0d window_full %0b",
                 $time, out_data.average, out_data.window_full);
        fail_count++;
      end else begin
        want = pending_averages.pop_front();
        if (out_data.average !== want.average) begin
          $display("%0t: average expected %0d got %0d",
                   $time, want.average, out_data.average);
          fail_count++;
        end
        if (out_data.window_full !== want.window_full) begin
          $display("%0t: window_full expected %0b got %0b",
                   $time, want.window_full, out_data.window_full);
          fail_count++;
        end
      end
    end
  end

endmodule
